// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL. Compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/lfrf_pkg.sv =====
package lfrf_pkg;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_W       = 11;
    localparam int FIELD_W     = 10;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Control that travels with each word down the cell row
    typedef struct packed {
        logic valid;
        logic last;
        logic live;
    } lfrf_ctl_t;

endpackage

// ===== rtl/core/longest_free_run_finder.sv =====
// Longest free run finder. Streams an allocation bitmap (1 = used) in as words
// of WORD_BITS entries, lowest entry in bit 0, and on the word flagged by
// s_tlast returns the start and length of the longest run of free entries,
// the earliest one on a tie. Entry 0 never counts, entries at or above
// entry_count are ignored, and words beyond MAX_ENTRIES/WORD_BITS in a scan
// are dropped (their tlast still closes the scan). One word is taken every
// cycle; each word passes a row of WORD_BITS cells, one bitmap bit per cell,
// and then a merge stage that joins it to the run carried from earlier words
// and registers the result of a scan once its last word is through. The only
// stall is a result waiting in the output register: s_tready drops then.
// m_tdata is {3'b0, best_length, best_start, found}; found is 0 with start and
// length 0 when no free entry exists. Write entry_count only while idle.
module longest_free_run_finder #(
    parameter int MAX_ENTRIES = 1024,
    parameter int WORD_BITS   = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lfrf_pkg::IN_TDATA_W-1:0]  s_tdata,   // [63:0] word_bits
    input  logic                             s_tlast,   // last_word
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lfrf_pkg::OUT_TDATA_W-1:0] m_tdata,   // [0] found, [10:1] best_start,
                                                        // [20:11] best_length, [23:21] zero
    input  logic                             cfg_we,
    input  logic [lfrf_pkg::CFG_W-1:0]       cfg_wdata  // entry_count
);
    import lfrf_pkg::*;

    `include "assert_macros.svh"

    localparam int LB          = $clog2(WORD_BITS+1);
    localparam int IW          = $clog2(MAX_ENTRIES);
    localparam int BW          = IW + 1;
    localparam int CW          = (BW > CFG_W) ? BW : CFG_W;
    localparam int CAP_ENTRIES = (MAX_ENTRIES / WORD_BITS) * WORD_BITS;

    logic [CFG_W-1:0] entry_count_reg;
    logic [BW-1:0]    in_base_reg;
    logic             adv;
    logic             live;
    logic [WORD_BITS-1:0] used_word;

    lfrf_ctl_t            ctl_c      [0:WORD_BITS];
    logic [WORD_BITS-1:0] used_c     [0:WORD_BITS];
    logic                 af_c       [0:WORD_BITS];
    logic [LB-1:0]        pre_c      [0:WORD_BITS];
    logic [LB-1:0]        cur_len_c  [0:WORD_BITS];
    logic [LB-1:0]        cur_st_c   [0:WORD_BITS];
    logic [LB-1:0]        in_len_c   [0:WORD_BITS];
    logic [LB-1:0]        in_st_c    [0:WORD_BITS];

    logic                 out_found;
    logic [FIELD_W-1:0]   out_start, out_length;

    // Advance the whole row unless a result sits unclaimed at the output
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_wdata;
        end
    end

    // Index of bit 0 of the incoming word; stops at capacity, cleared by tlast
    assign live = in_base_reg < BW'(CAP_ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_base_reg <= '0;
        end
        else if (s_tvalid && s_tready)
        begin
            if (s_tlast)
            begin
                in_base_reg <= '0;
            end
            else if (live)
            begin
                in_base_reg <= in_base_reg + BW'(WORD_BITS);
            end
        end
    end

    // Mark skipped entries (entry 0, at or above the count, dropped words) as used
    always_comb
    begin
        logic [CW-1:0] idx;
        for (int k = 0; k < WORD_BITS; k++)
        begin
            idx = CW'(in_base_reg) + CW'(k);
            used_word[k] = s_tdata[k] |
                           !(live && idx != '0 && idx < CW'(entry_count_reg));
        end
    end

    assign ctl_c[0]     = '{valid: s_tvalid, last: s_tlast, live: live};
    assign used_c[0]    = used_word;
    assign af_c[0]      = 1'b1;
    assign pre_c[0]     = '0;
    assign cur_len_c[0] = '0;
    assign cur_st_c[0]  = '0;
    assign in_len_c[0]  = '0;
    assign in_st_c[0]   = '0;

    for (genvar g = 0; g < WORD_BITS; g++)
    begin : g_cell
        lfrf_cell #(
            .WORD_BITS (WORD_BITS),
            .POS       (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .adv           (adv),
            .ctl_in        (ctl_c[g]),
            .used_in       (used_c[g]),
            .all_free_in   (af_c[g]),
            .pre_len_in    (pre_c[g]),
            .cur_len_in    (cur_len_c[g]),
            .cur_start_in  (cur_st_c[g]),
            .in_len_in     (in_len_c[g]),
            .in_start_in   (in_st_c[g]),
            .ctl_out       (ctl_c[g+1]),
            .used_out      (used_c[g+1]),
            .all_free_out  (af_c[g+1]),
            .pre_len_out   (pre_c[g+1]),
            .cur_len_out   (cur_len_c[g+1]),
            .cur_start_out (cur_st_c[g+1]),
            .in_len_out    (in_len_c[g+1]),
            .in_start_out  (in_st_c[g+1])
        );
    end

    lfrf_merge #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WORD_BITS   (WORD_BITS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .ctl_in       (ctl_c[WORD_BITS]),
        .all_free_in  (af_c[WORD_BITS]),
        .pre_len_in   (pre_c[WORD_BITS]),
        .cur_len_in   (cur_len_c[WORD_BITS]),
        .cur_start_in (cur_st_c[WORD_BITS]),
        .in_len_in    (in_len_c[WORD_BITS]),
        .in_start_in  (in_st_c[WORD_BITS]),
        .out_valid    (m_tvalid),
        .out_found    (out_found),
        .out_start    (out_start),
        .out_length   (out_length)
    );

    assign m_tdata = {(OUT_TDATA_W - 1 - 2*FIELD_W)'(0), out_length, out_start, out_found};

    `ASSERT_IMPL(a_found_len, clk, rst_n, m_tvalid, out_found == (out_length != '0), "found disagrees with run length")
    `ASSERT_IMPL(a_none_zero, clk, rst_n, m_tvalid && !out_found, out_start == '0, "no run but start is nonzero")
    `ASSERT_IMPL(a_base_cap, clk, rst_n, 1'b1, in_base_reg <= BW'(CAP_ENTRIES), "word base ran past capacity")

endmodule

// ===== rtl/core/lfrf_cell.sv =====
module lfrf_cell #(
    parameter int WORD_BITS = 64,
    parameter int POS       = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  lfrf_pkg::lfrf_ctl_t          ctl_in,
    input  logic [WORD_BITS-1:0]         used_in,
    input  logic                         all_free_in,
    input  logic [$clog2(WORD_BITS+1)-1:0] pre_len_in,
    input  logic [$clog2(WORD_BITS+1)-1:0] cur_len_in,
    input  logic [$clog2(WORD_BITS+1)-1:0] cur_start_in,
    input  logic [$clog2(WORD_BITS+1)-1:0] in_len_in,
    input  logic [$clog2(WORD_BITS+1)-1:0] in_start_in,
    output lfrf_pkg::lfrf_ctl_t          ctl_out,
    output logic [WORD_BITS-1:0]         used_out,
    output logic                         all_free_out,
    output logic [$clog2(WORD_BITS+1)-1:0] pre_len_out,
    output logic [$clog2(WORD_BITS+1)-1:0] cur_len_out,
    output logic [$clog2(WORD_BITS+1)-1:0] cur_start_out,
    output logic [$clog2(WORD_BITS+1)-1:0] in_len_out,
    output logic [$clog2(WORD_BITS+1)-1:0] in_start_out
);
    import lfrf_pkg::*;

    localparam int LB = $clog2(WORD_BITS+1);

    lfrf_ctl_t       ctl_reg;
    logic [WORD_BITS-1:0] used_reg;
    logic            all_free_reg, all_free_next;
    logic [LB-1:0]   pre_len_reg, pre_len_next;
    logic [LB-1:0]   cur_len_reg, cur_len_next;
    logic [LB-1:0]   cur_start_reg, cur_start_next;
    logic [LB-1:0]   in_len_reg, in_len_next;
    logic [LB-1:0]   in_start_reg, in_start_next;
    logic            free;

    // Fold bit POS into the word summary: leading run, open run, best inner run
    always_comb
    begin
        free           = ~used_in[POS];
        all_free_next  = all_free_in & free;
        pre_len_next   = all_free_next ? pre_len_in + LB'(1) : pre_len_in;
        cur_len_next   = free ? cur_len_in + LB'(1) : '0;
        cur_start_next = (free && cur_len_in == '0) ? LB'(POS) : cur_start_in;
        in_len_next    = in_len_in;
        in_start_next  = in_start_in;
        if (free && !all_free_in && cur_len_next > in_len_in)
        begin
            in_len_next   = cur_len_next;
            in_start_next = cur_start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            used_reg      <= used_in;
            all_free_reg  <= all_free_next;
            pre_len_reg   <= pre_len_next;
            cur_len_reg   <= cur_len_next;
            cur_start_reg <= cur_start_next;
            in_len_reg    <= in_len_next;
            in_start_reg  <= in_start_next;
        end
    end

    assign ctl_out       = ctl_reg;
    assign used_out      = used_reg;
    assign all_free_out  = all_free_reg;
    assign pre_len_out   = pre_len_reg;
    assign cur_len_out   = cur_len_reg;
    assign cur_start_out = cur_start_reg;
    assign in_len_out    = in_len_reg;
    assign in_start_out  = in_start_reg;

endmodule

// ===== rtl/core/lfrf_merge.sv =====
module lfrf_merge #(
    parameter int MAX_ENTRIES = 1024,
    parameter int WORD_BITS   = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  lfrf_pkg::lfrf_ctl_t            ctl_in,
    input  logic                           all_free_in,
    input  logic [$clog2(WORD_BITS+1)-1:0] pre_len_in,
    input  logic [$clog2(WORD_BITS+1)-1:0] cur_len_in,
    input  logic [$clog2(WORD_BITS+1)-1:0] cur_start_in,
    input  logic [$clog2(WORD_BITS+1)-1:0] in_len_in,
    input  logic [$clog2(WORD_BITS+1)-1:0] in_start_in,
    output logic                           out_valid,
    output logic                           out_found,
    output logic [lfrf_pkg::FIELD_W-1:0]   out_start,
    output logic [lfrf_pkg::FIELD_W-1:0]   out_length
);
    import lfrf_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int BW = IW + 1;

    logic [BW-1:0] base_reg, base_next;
    logic [IW-1:0] run_start_reg, run_start_next;
    logic [IW-1:0] run_len_reg, run_len_next;
    logic [IW-1:0] best_start_reg, best_start_next;
    logic [IW-1:0] best_len_reg, best_len_next;
    logic          out_valid_reg;
    logic          out_found_reg;
    logic [FIELD_W-1:0] out_start_reg, out_length_reg;

    logic [IW-1:0] base;
    logic [IW-1:0] ext_len, ext_start;
    logic [IW-1:0] b1_start, b1_len;
    logic [IW-1:0] inner_len, inner_start;
    logic          take;

    always_comb
    begin
        base      = base_reg[IW-1:0];
        ext_len   = run_len_reg + IW'(pre_len_in);
        ext_start = (run_len_reg == '0) ? base : run_start_reg;

        // Open run extended by the word's leading run, then the best inner run
        b1_start = best_start_reg;
        b1_len   = best_len_reg;
        if (ext_len > best_len_reg)
        begin
            b1_start = ext_start;
            b1_len   = ext_len;
        end
        inner_len   = IW'(in_len_in);
        inner_start = base + IW'(in_start_in);

        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        base_next       = base_reg;
        if (ctl_in.live)
        begin
            best_start_next = b1_start;
            best_len_next   = b1_len;
            if (inner_len > b1_len)
            begin
                best_start_next = inner_start;
                best_len_next   = inner_len;
            end
            if (all_free_in)
            begin
                run_start_next = ext_start;
                run_len_next   = ext_len;
            end
            else
            begin
                run_start_next = base + IW'(cur_start_in);
                run_len_next   = IW'(cur_len_in);
            end
            base_next = base_reg + BW'(WORD_BITS);
        end
    end

    assign take = adv && ctl_in.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= ctl_in.valid && ctl_in.last;
            end
            if (take)
            begin
                if (ctl_in.last)
                begin
                    base_reg       <= '0;
                    run_start_reg  <= '0;
                    run_len_reg    <= '0;
                    best_start_reg <= '0;
                    best_len_reg   <= '0;
                end
                else
                begin
                    base_reg       <= base_next;
                    run_start_reg  <= run_start_next;
                    run_len_reg    <= run_len_next;
                    best_start_reg <= best_start_next;
                    best_len_reg   <= best_len_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && ctl_in.last)
        begin
            out_found_reg  <= best_len_next != '0;
            out_start_reg  <= FIELD_W'(best_start_next);
            out_length_reg <= FIELD_W'(best_len_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_found  = out_found_reg;
    assign out_start  = out_start_reg;
    assign out_length = out_length_reg;

endmodule
